// ----- hw/rtl/brm_pkg.sv -----
// Shared types, constants and command codes for the byte register machine.
package brm_pkg;

    localparam int MEM_DEPTH = 64;
    localparam int REG_COUNT = 7;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int REG_AW    = $clog2(REG_COUNT);

    localparam int CMD_W   = 4;
    localparam int REG_W   = 3;
    localparam int CNT_W   = 3;
    localparam int ADDR_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int FULL_W  = 17;   // widest untruncated result (8x8 product plus sign)

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_INC   = 4'd4,
        CMD_DEC   = 4'd5,
        CMD_ROL   = 4'd6,
        CMD_ROR   = 4'd7,
        CMD_SHL   = 4'd8,
        CMD_SHR   = 4'd9,
        CMD_LOAD  = 4'd10,
        CMD_STORE = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CAP_B,
        ST_PREP,
        ST_DIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mem_addr;
        logic [CNT_W-1:0]  shift_count;
        logic [REG_W-1:0]  dst_reg;
        logic [REG_W-1:0]  src_reg;
        logic [CMD_W-1:0]  cmd;
    } instr_t;

    typedef struct packed {
        logic ovf;
        logic unf;
        logic cry;
        logic zro;
    } flags_t;

    typedef struct packed {
        logic              div_zero_error;
        flags_t            flags;
        logic [BYTE_W-1:0] value;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // take a new instruction
        logic rd_src;     // register file read address = source
        logic cap_a;      // capture destination operand
        logic cap_b;      // capture source operand
        logic div_init;   // load divider
        logic div_step;   // one quotient bit
        logic wb;         // commit and load output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_run;    // divide with nonzero divisor
        logic div_last;   // final quotient bit this cycle
        logic out_free;   // output register can take a result
    } dp_sts_t;

endpackage

// ----- hw/rtl/brm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module brm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/brm_datapath.sv -----
// Datapath: register file, data memory, ALU, serial divider, flags, output register.
module brm_datapath import brm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  dp_cmd_t cmd,
    input  instr_t  s_instr,
    input  logic    m_ready,
    output dp_sts_t sts,
    output logic    out_valid,
    output result_t out_data
);

    instr_t             instr_reg;
    logic [BYTE_W-1:0]  a_reg, b_reg;
    logic [BYTE_W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    flags_t             flags_reg, flags_next;
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [MEM_DEPTH-1:0] mem_valid_reg;
    logic               rf_vld_reg, mem_vld_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    // register file and memory ports
    logic [REG_W-1:0]   rf_idx;
    logic               rf_hit, rf_we, dst_hit;
    logic [BYTE_W-1:0]  rf_rdata, rf_rd;
    logic               mem_hit, mem_we;
    logic [BYTE_W-1:0]  mem_rdata, mem_rd;

    assign rf_idx  = cmd.rd_src ? instr_reg.src_reg : instr_reg.dst_reg;
    assign rf_hit  = 32'(rf_idx) < REG_COUNT;
    assign dst_hit = 32'(instr_reg.dst_reg) < REG_COUNT;
    assign mem_hit = 32'(instr_reg.mem_addr) < MEM_DEPTH;
    assign rf_rd   = rf_vld_reg ? rf_rdata : '0;
    assign mem_rd  = mem_vld_reg ? mem_rdata : '0;

    brm_ram #(.WIDTH(BYTE_W), .DEPTH(REG_COUNT)) u_rf (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (REG_AW'(instr_reg.dst_reg)),
        .wdata (out_data_next.value),
        .raddr (REG_AW'(rf_idx)),
        .rdata (rf_rdata)
    );

    brm_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (MEM_AW'(instr_reg.mem_addr)),
        .wdata (out_data_next.value),
        .raddr (MEM_AW'(instr_reg.mem_addr)),
        .rdata (mem_rdata)
    );

    // divider step: restoring, one quotient bit per cycle
    logic [BYTE_W-1:0] shifted;
    logic [BYTE_W:0]   trial;
    assign shifted = {rem_reg[BYTE_W-2:0], quo_reg[BYTE_W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, dvs_reg};

    // execute
    logic signed [FULL_W-1:0] a_x, b_x, full;
    logic signed [2*BYTE_W-1:0] prod;
    logic [FULL_W-1:0] q_ext;
    logic [2*BYTE_W-1:0] rot_l, rot_r;
    logic arith, writes_dst, div_zero;

    assign a_x   = FULL_W'($signed(a_reg));
    assign b_x   = FULL_W'($signed(b_reg));
    assign prod  = $signed(a_reg) * $signed(b_reg);
    assign q_ext = {{(FULL_W-BYTE_W){1'b0}}, quo_reg};
    assign rot_l = {a_reg, a_reg} << instr_reg.shift_count;
    assign rot_r = {a_reg, a_reg} >> instr_reg.shift_count;

    always_comb begin
        full       = '0;
        arith      = 1'b0;
        writes_dst = 1'b0;
        div_zero   = 1'b0;
        out_data_next = '0;
        case (op_t'(instr_reg.cmd))
            CMD_ADD: begin full = a_x + b_x; arith = 1'b1; end
            CMD_SUB: begin full = a_x - b_x; arith = 1'b1; end
            CMD_MUL: begin full = FULL_W'(prod); arith = 1'b1; end
            CMD_DIV: begin
                if (b_reg == '0) begin
                    div_zero = 1'b1;
                end else begin
                    full  = neg_reg ? -$signed(q_ext) : $signed(q_ext);
                    arith = 1'b1;
                end
            end
            CMD_INC: begin full = a_x + FULL_W'(1); arith = 1'b1; end
            CMD_DEC: begin full = a_x - FULL_W'(1); arith = 1'b1; end
            CMD_ROL: begin
                out_data_next.value = rot_l[2*BYTE_W-1:BYTE_W];
                writes_dst = 1'b1;
            end
            CMD_ROR: begin
                out_data_next.value = rot_r[BYTE_W-1:0];
                writes_dst = 1'b1;
            end
            CMD_SHL: begin
                out_data_next.value = a_reg << instr_reg.shift_count;
                writes_dst = 1'b1;
            end
            CMD_SHR: begin
                out_data_next.value = BYTE_W'($signed(a_reg) >>> instr_reg.shift_count);
                writes_dst = 1'b1;
            end
            CMD_LOAD: begin
                out_data_next.value = mem_rd;
                writes_dst = 1'b1;
            end
            CMD_STORE: out_data_next.value = b_reg;
            default: ;
        endcase
        if (arith) begin
            out_data_next.value = full[BYTE_W-1:0];
            writes_dst = 1'b1;
        end
        flags_next = flags_reg;
        if (arith) begin
            flags_next.ovf = full > FULL_W'(127);
            flags_next.unf = full < -FULL_W'(128);
            flags_next.cry = flags_next.ovf | flags_next.unf;
            flags_next.zro = full == '0;
        end
        out_data_next.flags          = flags_next;
        out_data_next.div_zero_error = div_zero;
    end

    assign rf_we  = cmd.wb && writes_dst && dst_hit;
    assign mem_we = cmd.wb && (op_t'(instr_reg.cmd) == CMD_STORE) && mem_hit;

    assign out_valid_next = cmd.wb ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            rf_valid_reg  <= '0;
            mem_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            rf_vld_reg    <= 1'b0;
            mem_vld_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            rf_vld_reg    <= rf_hit && rf_valid_reg[REG_AW'(rf_idx)];
            mem_vld_reg   <= mem_hit && mem_valid_reg[MEM_AW'(instr_reg.mem_addr)];
            if (cmd.wb) begin
                flags_reg <= flags_next;
            end
            if (rf_we) begin
                rf_valid_reg[REG_AW'(instr_reg.dst_reg)] <= 1'b1;
            end
            if (mem_we) begin
                mem_valid_reg[MEM_AW'(instr_reg.mem_addr)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            instr_reg <= s_instr;
        end
        if (cmd.cap_a) begin
            a_reg <= rf_rd;
        end
        if (cmd.cap_b) begin
            b_reg <= rf_rd;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= a_reg[BYTE_W-1] ? -a_reg : a_reg;
            dvs_reg <= b_reg[BYTE_W-1] ? -b_reg : b_reg;
            neg_reg <= a_reg[BYTE_W-1] ^ b_reg[BYTE_W-1];
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial[BYTE_W] ? shifted : trial[BYTE_W-1:0];
            quo_reg <= {quo_reg[BYTE_W-2:0], ~trial[BYTE_W]};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.wb) begin
            out_data_reg <= out_data_next;
        end
    end

    assign sts.div_run  = (op_t'(instr_reg.cmd) == CMD_DIV) && (b_reg != '0);
    assign sts.div_last = cnt_reg == '1;
    assign sts.out_free = !out_valid_reg || m_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/brm_ctrl.sv -----
// Controller: sequences operand reads, the divider and write-back.
module brm_ctrl import brm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
                if (s_valid) begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: begin
                cmd.cap_a  = 1'b1;
                cmd.rd_src = 1'b1;
                state_next = ST_CAP_B;
            end
            ST_CAP_B: begin
                cmd.cap_b  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.div_init = 1'b1;
                state_next   = sts.div_run ? ST_DIV : ST_WB;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (sts.out_free) begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/byte_register_machine_execute.sv -----
// Top level of the byte register machine execute stage.
//
//  channel | dir | ports                     | beat
//  --------+-----+---------------------------+---------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata | one decoded instruction
//  m_      | out | m_tvalid m_tready m_tdata | written byte, flags, div error
//
// One instruction is in flight at a time: the next is accepted only after write-back.
// The two operand reads share the one register-file read port; the divider
// retires one quotient bit per cycle until the quotient byte is complete.
// Reset: synchronous, active low; registers, memory and flags read as zero
// (per-entry valid bits, no clearing pass).
// Stalls: the result sits in an output register; the next instruction is taken
// and executed meanwhile and only waits at write-back while m_tready is low.
module byte_register_machine_execute import brm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [3:0] cmd, [6:4] src_reg, [9:7] dst_reg, [12:10] shift_count,
    // [18:13] mem_addr, [23:19] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] value, [8] overflow_flag, [9] underflow_flag, [10] carry_flag,
    // [11] zero_flag, [12] div_zero_error, [15:13] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    instr_t  s_instr;
    result_t res;

    // unpack fields, lowest first
    assign s_instr.cmd         = s_tdata[3:0];
    assign s_instr.src_reg     = s_tdata[6:4];
    assign s_instr.dst_reg     = s_tdata[9:7];
    assign s_instr.shift_count = s_tdata[12:10];
    assign s_instr.mem_addr    = s_tdata[18:13];

    brm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    brm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_instr   (s_instr),
        .m_ready   (m_tready),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_data  (res)
    );

    // pack result, value in the low byte
    assign m_tdata = {3'b000, res.div_zero_error, res.flags.zro, res.flags.cry,
                      res.flags.unf, res.flags.ovf, res.value};

endmodule

// ----- hw/rtl/brm_checker.sv -----
// Port-level checks for the execute stage, bound to the top level.
module brm_checker import brm_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // carry is the union of overflow and underflow
    a_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10] == (m_tdata[8] | m_tdata[9]))
        else $error("carry flag mismatch");

    // overflow and underflow never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
        else $error("overflow and underflow both set");

    // divide by zero reports a zero byte
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[7:0] == 8'h00)
        else $error("nonzero value on divide by zero");

    // one instruction in flight: no accept on the cycle after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back accept");

endmodule

bind byte_register_machine_execute brm_checker u_brm_checker (.*);
